FILE: hdl/lcse_pkg.sv
// Shared constants and register codes for the lane centre and steering error block.
package lcse_pkg;

	localparam int unsigned WINDOW_SPAN_DEF = 30;

	localparam logic [6:0] COUNT_MAX = 7'd127;

	typedef enum logic [2:0] {
		REG_FIRST_ROW   = 3'd0,
		REG_NEAR_ROW    = 3'd1,
		REG_FAR_ROW     = 3'd2,
		REG_CENTER_REF  = 3'd3,
		REG_INIT_HALF_W = 3'd4,
		REG_ERROR_LIMIT = 3'd5
	} reg_index_t;

	localparam logic [5:0] FIRST_ROW_RST  = 6'd2;
	localparam logic [5:0] NEAR_ROW_RST   = 6'd10;
	localparam logic [5:0] FAR_ROW_RST    = 6'd45;
	localparam logic [7:0] CENTER_REF_RST = 8'd98;
	localparam logic [6:0] INIT_HALF_RST  = 7'd40;
	localparam logic [7:0] ERR_LIMIT_RST  = 8'd33;

endpackage

FILE: hdl/lane_center_and_steer_error.sv
// Row centre fill, windowed deviation sums and serial steering error division.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | in_valid/in_stall  | row_index, edges, lost flags, invalid_in, last_row
//  out     | output    | out_valid/out_stall| row_center, row_invalid, steer_error, error_ready
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An ordinary row is captured in ST_IDLE, computed in ST_ROW and loaded into the result register from ST_PUT.
// The last row of a frame also passes through the restoring divider in ST_DIV and the clamp in ST_CLAMP.
// A new beat is taken only once the previous result has been loaded.
// Reset restores the register defaults and clears the frame sums at once.
// While a result is stalled, the next row is taken and computed, then waits to be loaded.
module lane_center_and_steer_error
	import lcse_pkg::*;
#(
	parameter int unsigned WINDOW_SPAN = WINDOW_SPAN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [5:0]        row_index,
	input  logic [7:0]        left_edge,
	input  logic [7:0]        right_edge,
	input  logic              left_lost,
	input  logic              right_lost,
	input  logic              invalid_in,
	input  logic              last_row,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        row_center,
	output logic              row_invalid,
	output logic signed [8:0] steer_error,
	output logic              error_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_DIV,
		ST_CLAMP,
		ST_PUT
	} state_t;

	localparam logic [6:0] SPAN = 7'(WINDOW_SPAN);

	state_t state_q;

	logic [5:0] first_row_q, near_row_q, far_row_q;
	logic [7:0] center_ref_q, err_limit_q;
	logic [6:0] init_half_q;

	logic [6:0]  half_width_q;
	logic [15:0] full_sum_q, near_sum_q;
	logic [6:0]  full_count_q, near_count_q;

	logic [5:0] row_q;
	logic [7:0] left_q, right_q;
	logic       llost_q, rlost_q, inv_q, last_q;

	logic [7:0]  center_q;
	logic        invalid_q;
	logic signed [8:0] err_q;

	logic [15:0] dvd_q;
	logic [6:0]  rem_q, cnt_q;
	logic        neg_q;
	logic [3:0]  step_q;

	logic              out_valid_q;
	logic [7:0]        row_center_q;
	logic              row_invalid_q;
	logic signed [8:0] steer_error_q;
	logic              error_ready_q;

	logic [7:0]  center_c;
	logic        invalid_c;
	logic [6:0]  hw_c;
	logic [8:0]  sum9_c;
	logic [15:0] dev_c;
	logic [5:0]  limit_c;
	logic        use_full_c;
	logic [15:0] sel_sum_c;
	logic [7:0]  trial_c;
	logic        qbit_c;
	logic signed [16:0] err_c, lim_c;

	always_comb begin
		center_c  = 8'd0;
		invalid_c = inv_q;
		hw_c      = half_width_q;
		sum9_c    = 9'd0;
		if (!llost_q && rlost_q) begin
			if (left_q > {1'b0, half_width_q}) begin
				center_c = left_q - {1'b0, half_width_q};
			end else begin
				invalid_c = 1'b1;
			end
		end else if (llost_q && !rlost_q) begin
			sum9_c = {1'b0, right_q} + {2'b00, half_width_q};
			if (right_q > {1'b0, half_width_q}) begin
				center_c = sum9_c[8] ? 8'hFF : sum9_c[7:0];
			end else begin
				invalid_c = 1'b1;
			end
		end else begin
			sum9_c   = {1'b0, left_q} + {1'b0, right_q};
			center_c = sum9_c[8:1];
			hw_c     = (left_q >= right_q) ? 7'((left_q - right_q) >> 1) : 7'd0;
		end
	end

	always_comb begin
		dev_c      = 16'({{8{1'b0}}, center_c} - {{8{1'b0}}, center_ref_q});
		limit_c    = (row_q < far_row_q) ? row_q : far_row_q;
		use_full_c = ({1'b0, limit_c} < ({1'b0, first_row_q} + SPAN)) ||
		             (limit_c <= near_row_q);
		sel_sum_c  = use_full_c ? full_sum_q : near_sum_q;
	end

	always_comb begin
		trial_c = {rem_q, dvd_q[15]};
		qbit_c  = trial_c >= {1'b0, cnt_q};
	end

	always_comb begin
		if (cnt_q == 7'd0) begin
			err_c = 17'sd0;
		end else if (neg_q) begin
			err_c = -$signed({1'b0, dvd_q});
		end else begin
			err_c = $signed({1'b0, dvd_q});
		end
		lim_c = $signed({9'd0, err_limit_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_row_q  <= FIRST_ROW_RST;
			near_row_q   <= NEAR_ROW_RST;
			far_row_q    <= FAR_ROW_RST;
			center_ref_q <= CENTER_REF_RST;
			init_half_q  <= INIT_HALF_RST;
			err_limit_q  <= ERR_LIMIT_RST;
			half_width_q <= INIT_HALF_RST;
			full_sum_q   <= 16'd0;
			near_sum_q   <= 16'd0;
			full_count_q <= 7'd0;
			near_count_q <= 7'd0;
			step_q       <= 4'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_PUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FIRST_ROW:   first_row_q  <= cfg_data[5:0];
					REG_NEAR_ROW:    near_row_q   <= cfg_data[5:0];
					REG_FAR_ROW:     far_row_q    <= cfg_data[5:0];
					REG_CENTER_REF:  center_ref_q <= cfg_data;
					REG_INIT_HALF_W: begin
						init_half_q  <= cfg_data[6:0];
						half_width_q <= cfg_data[6:0];
					end
					REG_ERROR_LIMIT: err_limit_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						row_q   <= row_index;
						left_q  <= left_edge;
						right_q <= right_edge;
						llost_q <= left_lost;
						rlost_q <= right_lost;
						inv_q   <= invalid_in;
						last_q  <= last_row;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					center_q  <= center_c;
					invalid_q <= invalid_c;
					err_q     <= 9'sd0;
					if (last_q) begin
						dvd_q        <= sel_sum_c[15] ? 16'(-sel_sum_c) : sel_sum_c;
						neg_q        <= sel_sum_c[15];
						cnt_q        <= use_full_c ? full_count_q : near_count_q;
						rem_q        <= 7'd0;
						step_q       <= 4'd0;
						half_width_q <= init_half_q;
						full_sum_q   <= 16'd0;
						near_sum_q   <= 16'd0;
						full_count_q <= 7'd0;
						near_count_q <= 7'd0;
						state_q      <= ST_DIV;
					end else begin
						half_width_q <= hw_c;
						if (!invalid_c && row_q < far_row_q) begin
							if (row_q >= first_row_q) begin
								full_sum_q <= full_sum_q + dev_c;
								if (full_count_q < COUNT_MAX) begin
									full_count_q <= full_count_q + 7'd1;
								end
							end
							if (row_q >= near_row_q) begin
								near_sum_q <= near_sum_q + dev_c;
								if (near_count_q < COUNT_MAX) begin
									near_count_q <= near_count_q + 7'd1;
								end
							end
						end
						state_q <= ST_PUT;
					end
				end
				ST_DIV: begin
					rem_q  <= qbit_c ? 7'(trial_c - {1'b0, cnt_q}) : trial_c[6:0];
					dvd_q  <= {dvd_q[14:0], qbit_c};
					step_q <= step_q + 4'd1;
					if (step_q == 4'hF) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (err_c >= lim_c) begin
						err_q <= 9'(lim_c);
					end else if (err_c <= -lim_c) begin
						err_q <= 9'(-lim_c);
					end else begin
						err_q <= 9'(err_c);
					end
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						row_center_q  <= center_q;
						row_invalid_q <= invalid_q;
						steer_error_q <= err_q;
						error_ready_q <= last_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign row_center  = row_center_q;
	assign row_invalid = row_invalid_q;
	assign steer_error = steer_error_q;
	assign error_ready = error_ready_q;

endmodule

FILE: tb/lane_center_and_steer_error_tb.sv
// Self-checking testbench for the lane centre and steering error block.
module lane_center_and_steer_error_tb
	import lcse_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

	typedef struct packed {
		logic [5:0] row_index;
		logic [7:0] left_edge;
		logic [7:0] right_edge;
		logic       left_lost;
		logic       right_lost;
		logic       invalid_in;
		logic       last_row;
	} row_beat_t;

	typedef struct packed {
		logic [7:0]        centre;
		logic              invalid;
		logic signed [8:0] steer;
		logic              ready;
	} row_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	row_beat_t in_beat = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] row_center;
	logic row_invalid;
	logic signed [8:0] steer_error;
	logic error_ready;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	row_beat_t pending_rows[$];
	row_result_t predicted_rows[$];
	int rows_total = 0;
	int rows_accepted = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit beat_taken = 1'b0;

	logic [5:0] cfg_first, cfg_near, cfg_far;
	logic [7:0] cfg_ref, cfg_limit;
	logic [6:0] cfg_half_init;
	logic [7:0] half_w;
	logic [15:0] full_sum, near_sum;
	logic [6:0] full_cnt, near_cnt;

	lane_center_and_steer_error dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.row_index  (in_beat.row_index),
		.left_edge  (in_beat.left_edge),
		.right_edge (in_beat.right_edge),
		.left_lost  (in_beat.left_lost),
		.right_lost (in_beat.right_lost),
		.invalid_in (in_beat.invalid_in),
		.last_row   (in_beat.last_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_center (row_center),
		.row_invalid(row_invalid),
		.steer_error(steer_error),
		.error_ready(error_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		half_w = {1'b0, cfg_half_init};
		full_sum = '0;
		full_cnt = '0;
		near_sum = '0;
		near_cnt = '0;
	endfunction

	function automatic row_result_t compute_row_result(row_beat_t b);
		row_result_t res;
		logic [8:0] wide;
		logic [7:0] centre;
		logic [15:0] dev;
		logic [5:0] limit;
		logic bad;
		bit use_full;
		int sum, cnt, mean, lim;
		bad = b.invalid_in;
		mean = 0;
		if (!b.left_lost && b.right_lost) begin
			if (b.left_edge > half_w)
				centre = b.left_edge - half_w;
			else begin
				centre = '0;
				bad = 1'b1;
			end
		end else if (b.left_lost && !b.right_lost) begin
			if (b.right_edge > half_w) begin
				wide = b.right_edge + half_w;
				centre = wide[8] ? 8'hFF : wide[7:0];
			end else begin
				centre = '0;
				bad = 1'b1;
			end
		end else begin
			wide = b.left_edge + b.right_edge;
			centre = wide[8:1];
			half_w = (b.left_edge >= b.right_edge) ? (b.left_edge - b.right_edge) >> 1 : '0;
		end
		if (!b.last_row) begin
			if (!bad && b.row_index < cfg_far) begin
				dev = 16'(centre) - 16'(cfg_ref);
				if (b.row_index >= cfg_first) begin
					full_sum += dev;
					if (full_cnt != COUNT_MAX)
						full_cnt++;
				end
				if (b.row_index >= cfg_near) begin
					near_sum += dev;
					if (near_cnt != COUNT_MAX)
						near_cnt++;
				end
			end
		end else begin
			limit = (b.row_index < cfg_far) ? b.row_index : cfg_far;
			use_full = (int'(limit) < int'(cfg_first) + int'(WINDOW_SPAN_DEF)) ||
				(limit <= cfg_near);
			sum = use_full ? int'($signed(full_sum)) : int'($signed(near_sum));
			cnt = use_full ? int'(full_cnt) : int'(near_cnt);
			lim = int'(cfg_limit);
			if (cnt != 0)
				mean = sum / cnt;
			if (mean >= lim)
				mean = lim;
			else if (mean <= -lim)
				mean = -lim;
			clear_frame();
		end
		res.centre = centre;
		res.invalid = bad;
		res.steer = mean[8:0];
		res.ready = b.last_row;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("ERROR: %s", msg);
	endtask

	function automatic int clip8(int v);
		return (v < 0) ? 0 : (v > 255) ? 255 : v;
	endfunction

	task automatic push_row(input int row, input int l, input int r,
			input bit ll, input bit rl, input bit inv, input bit last);
		row_beat_t b;
		b.row_index = 6'(row);
		b.left_edge = 8'(l);
		b.right_edge = 8'(r);
		b.left_lost = ll;
		b.right_lost = rl;
		b.invalid_in = inv;
		b.last_row = last;
		pending_rows.push_back(b);
		rows_total++;
	endtask

	// Rows climb from near the car with a drifting centre; the frame may be left open.
	task automatic queue_frame(input bit closed, input bit scrambled);
		int row, rows, hw, c, l, r;
		row = $urandom_range(0, 4);
		rows = $urandom_range(1, 24);
		hw = $urandom_range(4, 90);
		c = $urandom_range(30, 225);
		for (int k = 0; k < rows && row <= 63; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				l = $urandom_range(0, 40);
				r = $urandom_range(0, 40);
			end else begin
				l = c + hw + int'($urandom_range(0, 8)) - 4;
				r = c - hw + int'($urandom_range(0, 8)) - 4;
			end
			push_row(scrambled ? int'($urandom_range(0, 63)) : row, clip8(l), clip8(r),
				$urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
				$urandom_range(0, 99) < 8, 1'b0);
			row += $urandom_range(1, 3);
			c = clip8(c + int'($urandom_range(0, 10)) - 5);
		end
		if (closed)
			push_row(($urandom_range(0, 9) < 7) ? ((row > 63) ? 63 : row) :
				int'($urandom_range(0, 63)), clip8(c + hw), clip8(c - hw),
				$urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
				$urandom_range(0, 99) < 8, 1'b1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FIRST_ROW:   cfg_first = data[5:0];
			REG_NEAR_ROW:    cfg_near = data[5:0];
			REG_FAR_ROW:     cfg_far = data[5:0];
			REG_CENTER_REF:  cfg_ref = data;
			REG_INIT_HALF_W: begin
				cfg_half_init = data[6:0];
				half_w = {1'b0, data[6:0]};
			end
			REG_ERROR_LIMIT: cfg_limit = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int f, input int n, input int fr,
			input int ref_col, input int hw, input int lim);
		write_reg(REG_FIRST_ROW, {2'($urandom_range(0, 3)), 6'(f)});
		write_reg(REG_NEAR_ROW, {2'($urandom_range(0, 3)), 6'(n)});
		write_reg(REG_FAR_ROW, {2'($urandom_range(0, 3)), 6'(fr)});
		write_reg(REG_CENTER_REF, 8'(ref_col));
		write_reg(REG_INIT_HALF_W, {1'($urandom_range(0, 1)), 7'(hw)});
		write_reg(REG_ERROR_LIMIT, 8'(lim));
		write_reg(REG_UNMAPPED_A, 8'($urandom));
		write_reg(REG_UNMAPPED_B, 8'($urandom));
	endtask

	task automatic wait_drained();
		while (rows_accepted != rows_total || predicted_rows.size() != 0)
			@(negedge clk);
	endtask

	// Input beats are presented on the falling edge and held until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || beat_taken) begin
				if (pending_rows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_beat <= pending_rows.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
			beat_taken = 1'b0;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		row_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_rows.size() == 0)
					report_mismatch("result beat with nothing expected");
				else begin
					want = predicted_rows.pop_front();
					if (row_center !== want.centre)
						report_mismatch($sformatf("row_center got %0d want %0d",
							row_center, want.centre));
					if (row_invalid !== want.invalid)
						report_mismatch($sformatf("row_invalid got %0b want %0b",
							row_invalid, want.invalid));
					if (steer_error !== want.steer)
						report_mismatch($sformatf("steer_error got %0d want %0d",
							steer_error, want.steer));
					if (error_ready !== want.ready)
						report_mismatch($sformatf("error_ready got %0b want %0b",
							error_ready, want.ready));
				end
			end
			if (in_valid && !in_stall) begin
				predicted_rows.push_back(compute_row_result(in_beat));
				rows_accepted++;
				beat_taken = 1'b1;
			end
		end
	end

	initial begin
		int target, pick;
		cfg_first = FIRST_ROW_RST;
		cfg_near = NEAR_ROW_RST;
		cfg_far = FAR_ROW_RST;
		cfg_ref = CENTER_REF_RST;
		cfg_half_init = INIT_HALF_RST;
		cfg_limit = ERR_LIMIT_RST;
		clear_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_row(20, 150, 50, 0, 0, 0, 1);
		push_row(0, 255, 0, 0, 0, 0, 0);
		push_row(2, 0, 0, 1, 0, 0, 0);
		push_row(3, 0, 200, 1, 0, 0, 0);
		push_row(4, 100, 0, 0, 1, 0, 0);
		push_row(5, 200, 100, 0, 0, 0, 0);
		push_row(6, 180, 0, 0, 1, 0, 0);
		push_row(7, 30, 0, 0, 1, 0, 0);
		push_row(8, 0, 40, 1, 0, 0, 0);
		push_row(9, 10, 200, 1, 1, 0, 0);
		push_row(10, 60, 0, 0, 1, 0, 0);
		push_row(11, 200, 100, 0, 0, 1, 0);
		push_row(12, 255, 255, 0, 0, 0, 0);
		push_row(44, 250, 200, 0, 0, 0, 0);
		push_row(45, 250, 200, 0, 0, 0, 0);
		push_row(63, 240, 160, 0, 0, 0, 1);
		push_row(2, 20, 0, 0, 0, 0, 0);
		push_row(3, 20, 10, 0, 0, 0, 0);
		push_row(20, 10, 0, 1, 1, 0, 1);
		push_row(12, 200, 0, 0, 0, 0, 0);
		push_row(13, 210, 0, 0, 0, 0, 0);
		push_row(0, 140, 60, 0, 0, 0, 1);
		push_row(14, 190, 0, 0, 0, 0, 0);
		push_row(15, 192, 0, 0, 0, 0, 0);
		push_row(40, 200, 0, 0, 0, 0, 1);

		for (int p = 1; p <= 8; p++) begin
			wait_drained();
			case (p)
				2: set_regs(0, 0, 0, 0, 0, 0);
				3: set_regs(63, 63, 63, 255, 127, 255);
				5: set_regs(int'(FIRST_ROW_RST), int'(NEAR_ROW_RST), int'(FAR_ROW_RST),
					int'(CENTER_REF_RST), int'(INIT_HALF_RST), int'(ERR_LIMIT_RST));
				default: set_regs($urandom_range(0, 16), $urandom_range(0, 40),
					$urandom_range(8, 63), $urandom_range(50, 150), $urandom_range(0, 127),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
					$urandom_range(5, 60));
			endcase
			send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 68 : 29) : 0;
			stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 68 : 29) : 0;
			if (p == 5) begin
				// Enough full-scale rows to wrap both sums and saturate both counts.
				for (int k = 0; k < 210; k++)
					push_row($urandom_range(10, 44), 255, 255, 0, 0, 0, 0);
				push_row($urandom_range(0, 63), 255, 255, 0, 0, 0, 1);
			end
			target = rows_total + 80;
			while (rows_total < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 78)
					queue_frame(1'b1, 1'b0);
				else if (pick < 90) begin
					repeat ($urandom_range(1, 4))
						push_row($urandom_range(0, 63), $urandom_range(0, 255),
							$urandom_range(0, 255), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							$urandom_range(0, 7) == 0);
				end else
					queue_frame(1'b0, 1'($urandom_range(0, 1)));
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (predicted_rows.size() != 0)
			report_mismatch("expected results left over at the end");
		if (errors == 0)
			$display("lane_center_and_steer_error_tb OK");
		else
			$display("lane_center_and_steer_error_tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("lane_center_and_steer_error_tb NOT OK");
		$finish;
	end

endmodule
